@@ rtl/lsch_pkg.sv @@
// Shared types, constants and the exponent table of the classifier head.
`default_nettype none
package lsch_pkg;

  localparam int MAX_LABELS_DEF = 16;
  localparam int MAX_HIDDEN_DEF = 1024;
  localparam int EXP_TABLE_SIZE = 256;
  localparam int EXP_IDX_W      = $clog2(EXP_TABLE_SIZE);
  localparam int COUNT_W        = 11;
  localparam int QUOT_W         = 34;

  localparam logic [63:0] LN2_Q30   = 64'd744261118;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_BIAS   = 2'd1,
    KIND_ELEM   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_NUM_LABELS  = 2'd0,
    REG_HIDDEN_SIZE = 2'd1,
    REG_INV_TEMP    = 2'd2,
    REG_THRESHOLD   = 2'd3
  } reg_e;

  // Element item as it travels down the row of cells.
  typedef struct packed {
    logic              valid;
    logic              acc_en;
    logic [6:0]        n_labels;
    logic signed [15:0] value;
  } tok_t;

  typedef logic [16:0] exp_tab_t [EXP_TABLE_SIZE];

  // Entry i holds 2^(-i/EXP_TABLE_SIZE) in Q16, from a Q30 Taylor series of e^-x.
  function automatic exp_tab_t build_exp_table();
    exp_tab_t    tab;
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    for (int i = 0; i < EXP_TABLE_SIZE; i++) begin
      x    = (64'(i) * LN2_Q30 + 64'(EXP_TABLE_SIZE / 2)) / EXP_TABLE_SIZE;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int k = 1; k <= 14; k++) begin
        term = ((term * x) >> 30) / 64'(k);
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      tab[i] = 17'((64'(sum) + 64'd8192) >> 14);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage
`default_nettype wire

@@ rtl/lsch_cell.sv @@
// One label cell: weight row, multiplier and accumulator, passing the element on.
`default_nettype none
module lsch_cell #(
  parameter int MaxHidden = lsch_pkg::MAX_HIDDEN_DEF,
  parameter int Idx       = 0,
  localparam int AW       = (MaxHidden > 1) ? $clog2(MaxHidden) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lsch_pkg::tok_t      tok_i,
  input  wire logic [AW-1:0]       addr_i,
  output lsch_pkg::tok_t           tok_o,
  output logic [AW-1:0]            addr_o,
  input  wire logic                wr_en_i,
  input  wire logic [AW-1:0]       wr_addr_i,
  input  wire logic [15:0]         wr_data_i,
  input  wire logic                clear_i,
  output logic signed [47:0]       acc_o
);

  logic [15:0]        mem [MaxHidden];
  logic [15:0]        rdata_q;
  lsch_pkg::tok_t     tok_q;
  logic [AW-1:0]      addr_q;
  logic signed [31:0] prod_q;
  logic               pvalid_q;
  logic signed [47:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rdata_q <= mem[addr_i];
    addr_q  <= addr_i;
    prod_q  <= $signed(rdata_q) * tok_q.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      pvalid_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      tok_q    <= tok_i;
      pvalid_q <= tok_q.valid && tok_q.acc_en && (7'(Idx) < tok_q.n_labels);
      if (clear_i) begin
        acc_q <= '0;
      end else if (pvalid_q) begin
        acc_q <= acc_q + 48'(prod_q);
      end
    end
  end

  assign tok_o  = tok_q;
  assign addr_o = addr_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

@@ rtl/lsch_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module lsch_div #(
  parameter int NW = lsch_pkg::QUOT_W,
  parameter int DW = 21
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic [NW-1:0]      quotient_o
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] dvs_q;
  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == CW'(NW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : DW'(trial);
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

@@ rtl/linear_softmax_classifier_head.sv @@
// Top level of the linear classifier head with softmax and argmax.
`default_nettype none
// Weight, bias and embedding items enter through start/busy. A weight or bias
// write leaves busy low. Each embedding element is handed to a row of
// MaxLabels cells, one per label, each holding its weight row and its
// accumulator; the element moves one cell per cycle, and busy stays high
// while it passes that row and the read and multiply stages of its last cell,
// and for the step that checks the count. The element marked end_of_vector
// then starts the result run: the logits, then the exponents, then the serial
// divider that forms the probabilities, each label by label, then one result
// item per label on consecutive cycles, the last one flagged by last_o. A
// length mismatch gives one error item instead. Result items are shown for
// exactly one cycle with result_valid_o and cannot be stalled by the
// receiver. The configuration port is always ready and should be written
// while idle.
module linear_softmax_classifier_head #(
  parameter int MaxLabels = lsch_pkg::MAX_LABELS_DEF,
  parameter int MaxHidden = lsch_pkg::MAX_HIDDEN_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         kind_i,
  input  wire logic [3:0]         label_index_i,
  input  wire logic [9:0]         element_index_i,
  input  wire logic signed [15:0] value_i,
  input  wire logic signed [31:0] bias_value_i,
  input  wire logic               end_of_vector_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  output logic                    result_valid_o,
  output logic                    status_o,
  output logic [3:0]              result_label_o,
  output logic [15:0]             probability_o,
  output logic [3:0]              choice_o,
  output logic                    confident_o,
  output logic                    last_o
);

  localparam int AW  = (MaxHidden > 1) ? $clog2(MaxHidden) : 1;
  localparam int LW  = $clog2(MaxLabels);
  localparam int SW  = 17 + $clog2(MaxLabels);
  localparam int NW  = lsch_pkg::QUOT_W;
  localparam int CNW = lsch_pkg::COUNT_W;
  localparam int DRW = $clog2(MaxLabels + 4);
  localparam int IW  = lsch_pkg::EXP_IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DRAIN, S_LOG, S_EXP, S_DIV, S_OUT
  } state_e;

  // Configuration registers.
  logic [4:0]  num_labels_q;
  logic [10:0] hidden_size_q;
  logic [15:0] inv_temp_q;
  logic [15:0] threshold_q;

  state_e           state_q;
  logic [CNW-1:0]   count_q;
  logic             eov_q;
  logic [DRW-1:0]   drain_q;
  logic [LW-1:0]    lab_q;
  logic [1:0]       sub_q;
  logic             clear_q;
  logic             div_start_q;

  logic signed [31:0] bias_q [MaxLabels];
  logic signed [23:0] logit_q [MaxLabels];
  logic [16:0]        exp_q [MaxLabels];
  logic [15:0]        prob_q [MaxLabels];
  logic signed [48:0] s_q;
  logic [39:0]        lo_q;
  logic signed [41:0] hi_q;
  logic signed [23:0] mx_q;
  logic [LW-1:0]      choice_q;
  logic [40:0]        t_q;
  logic [SW-1:0]      sum_q;

  logic        rv_q;
  logic        status_q;
  logic [3:0]  rlab_q;
  logic [15:0] prob_out_q;
  logic [3:0]  choice_out_q;
  logic        conf_q;
  logic        last_q;

  // Clamped configuration.
  logic [6:0]  n_w;
  logic [12:0] h_w;
  logic [15:0] it_w;
  logic        accept;
  logic        elem_acc;
  logic        lab_last;

  always_comb begin
    if (num_labels_q < 5'd2) begin
      n_w = 7'd2;
    end else if (7'(num_labels_q) > 7'(MaxLabels)) begin
      n_w = 7'(MaxLabels);
    end else begin
      n_w = 7'(num_labels_q);
    end
    if (hidden_size_q == 11'd0) begin
      h_w = 13'd1;
    end else if (13'(hidden_size_q) > 13'(MaxHidden)) begin
      h_w = 13'(MaxHidden);
    end else begin
      h_w = 13'(hidden_size_q);
    end
    it_w = (inv_temp_q == 16'd0) ? 16'd1 : inv_temp_q;
  end

  assign accept      = start && !busy;
  assign elem_acc    = accept && (kind_i == lsch_pkg::KIND_ELEM);
  assign lab_last    = 7'(lab_q) == (n_w - 7'd1);
  assign cfg_ready_o = 1'b1;

  // Row of label cells.
  lsch_pkg::tok_t     tok_w  [MaxLabels+1];
  logic [AW-1:0]      addr_w [MaxLabels+1];
  logic signed [47:0] acc_w  [MaxLabels];
  logic               wgt_ok;

  assign wgt_ok = accept && (kind_i == lsch_pkg::KIND_WEIGHT)
                  && (32'(label_index_i) < 32'(MaxLabels))
                  && (32'(element_index_i) < 32'(MaxHidden));

  assign tok_w[0].valid    = elem_acc;
  assign tok_w[0].acc_en   = 13'(count_q) < h_w;
  assign tok_w[0].n_labels = n_w;
  assign tok_w[0].value    = value_i;
  assign addr_w[0]         = AW'(count_q);

  for (genvar g = 0; g < MaxLabels; g++) begin : g_cell
    lsch_cell #(.MaxHidden(MaxHidden), .Idx(g)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok_w[g]),
      .addr_i   (addr_w[g]),
      .tok_o    (tok_w[g+1]),
      .addr_o   (addr_w[g+1]),
      .wr_en_i  (wgt_ok && (32'(label_index_i) == g)),
      .wr_addr_i(AW'(element_index_i)),
      .wr_data_i(value_i),
      .clear_i  (clear_q),
      .acc_o    (acc_w[g])
    );
  end

  // Shared divider for the probabilities.
  logic          div_done;
  logic [NW-1:0] quot;

  lsch_div #(.NW(NW), .DW(SW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .dividend_i(NW'({exp_q[lab_q], 16'b0}) + NW'(sum_q >> 1)),
    .divisor_i (sum_q),
    .done_o    (div_done),
    .quotient_o(quot)
  );

  // Datapath of the logit and exponent steps.
  logic signed [65:0] tot;
  logic signed [65:0] lsh;
  logic signed [23:0] lsat;
  logic [24:0]        dfull;
  logic [28:0]        idx_full;
  logic [IW-1:0]      idx;
  logic [8:0]         ip;
  logic [16:0]        e_w;

  always_comb begin
    tot = $signed({hi_q, 24'b0}) + $signed({26'b0, lo_q}) + 66'sd524288;
    lsh = tot >>> 20;
    if (lsh > 66'sd8388607) begin
      lsat = 24'sh7FFFFF;
    end else if (lsh < -66'sd8388608) begin
      lsat = 24'sh800000;
    end else begin
      lsat = lsh[23:0];
    end
    dfull    = 25'(mx_q) - 25'(logit_q[lab_q]);
    ip       = t_q[40:32];
    idx_full = (29'(t_q[31:16]) * 29'(lsch_pkg::EXP_TABLE_SIZE)) >> 16;
    idx      = IW'(idx_full);
    e_w      = (ip < 9'd17) ? (lsch_pkg::EXP_TABLE[idx] >> ip[4:0]) : 17'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_labels_q  <= 5'd2;
      hidden_size_q <= 11'd1024;
      inv_temp_q    <= 16'd256;
      threshold_q   <= 16'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lsch_pkg::reg_e'(cfg_index_i))
        lsch_pkg::REG_NUM_LABELS:  num_labels_q  <= cfg_data_i[4:0];
        lsch_pkg::REG_HIDDEN_SIZE: hidden_size_q <= cfg_data_i[10:0];
        lsch_pkg::REG_INV_TEMP:    inv_temp_q    <= cfg_data_i;
        lsch_pkg::REG_THRESHOLD:   threshold_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Payload stores of the result run.
  always_ff @(posedge clk_i) begin
    if (accept && (kind_i == lsch_pkg::KIND_BIAS)
        && (32'(label_index_i) < 32'(MaxLabels))) begin
      bias_q[LW'(label_index_i)] <= bias_value_i;
    end
    s_q  <= 49'(acc_w[lab_q]) + 49'(bias_q[lab_q]);
    lo_q <= 40'(s_q[23:0]) * 40'(it_w);
    hi_q <= 42'($signed(s_q[48:24])) * 42'($signed({1'b0, it_w}));
    t_q  <= 41'(dfull[23:0]) * 41'(lsch_pkg::LOG2E_Q16);
    if (state_q == S_LOG && sub_q == 2'd2) begin
      logit_q[lab_q] <= lsat;
    end
    if (state_q == S_EXP && sub_q == 2'd1) begin
      exp_q[lab_q] <= e_w;
    end
    if (state_q == S_DIV && div_done) begin
      prob_q[lab_q] <= (|quot[NW-1:16]) ? 16'hFFFF : quot[15:0];
    end
  end

  // Sequencer and registered result outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      eov_q        <= 1'b0;
      drain_q      <= '0;
      lab_q        <= '0;
      sub_q        <= '0;
      clear_q      <= 1'b0;
      div_start_q  <= 1'b0;
      mx_q         <= '0;
      choice_q     <= '0;
      sum_q        <= '0;
      rv_q         <= 1'b0;
      status_q     <= 1'b0;
      rlab_q       <= '0;
      prob_out_q   <= '0;
      choice_out_q <= '0;
      conf_q       <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      rv_q        <= 1'b0;
      clear_q     <= 1'b0;
      div_start_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (elem_acc) begin
            if (count_q != {CNW{1'b1}}) begin
              count_q <= count_q + 1'b1;
            end
            eov_q   <= end_of_vector_i;
            drain_q <= '0;
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain_q <= drain_q + 1'b1;
          if (drain_q == DRW'(MaxLabels + 3)) begin
            lab_q <= '0;
            sub_q <= '0;
            if (!eov_q) begin
              state_q <= S_IDLE;
            end else if (13'(count_q) != h_w) begin
              rv_q         <= 1'b1;
              status_q     <= 1'b1;
              rlab_q       <= '0;
              prob_out_q   <= '0;
              choice_out_q <= '0;
              conf_q       <= 1'b0;
              last_q       <= 1'b1;
              clear_q      <= 1'b1;
              count_q      <= '0;
              state_q      <= S_IDLE;
            end else begin
              state_q <= S_LOG;
            end
          end
        end
        S_LOG: begin
          sub_q <= sub_q + 1'b1;
          if (sub_q == 2'd2) begin
            sub_q <= '0;
            if (lab_q == '0 || lsat > mx_q) begin
              mx_q     <= lsat;
              choice_q <= lab_q;
            end
            if (lab_last) begin
              lab_q   <= '0;
              sum_q   <= '0;
              state_q <= S_EXP;
            end else begin
              lab_q <= lab_q + 1'b1;
            end
          end
        end
        S_EXP: begin
          sub_q <= sub_q + 1'b1;
          if (sub_q == 2'd1) begin
            sub_q <= '0;
            sum_q <= sum_q + SW'(e_w);
            if (lab_last) begin
              lab_q   <= '0;
              state_q <= S_DIV;
            end else begin
              lab_q <= lab_q + 1'b1;
            end
          end
        end
        S_DIV: begin
          if (sub_q == 2'd0) begin
            div_start_q <= 1'b1;
            sub_q       <= 2'd1;
          end else if (div_done) begin
            sub_q <= '0;
            if (lab_last) begin
              lab_q   <= '0;
              state_q <= S_OUT;
            end else begin
              lab_q <= lab_q + 1'b1;
            end
          end
        end
        S_OUT: begin
          rv_q         <= 1'b1;
          status_q     <= 1'b0;
          rlab_q       <= 4'(lab_q);
          prob_out_q   <= prob_q[lab_q];
          choice_out_q <= 4'(choice_q);
          conf_q       <= prob_q[choice_q] >= threshold_q;
          last_q       <= lab_last;
          lab_q        <= lab_q + 1'b1;
          if (lab_last) begin
            clear_q <= 1'b1;
            count_q <= '0;
            lab_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = state_q != S_IDLE;
  assign result_valid_o = rv_q;
  assign status_o       = status_q;
  assign result_label_o = rlab_q;
  assign probability_o  = prob_out_q;
  assign choice_o       = choice_out_q;
  assign confident_o    = conf_q;
  assign last_o         = last_q;

  // An error item always closes its run.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> last_o)
    else $error("error item without last");

  // A run of result items is contiguous.
  a_run_contig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("gap inside a result run");

  // Labels within a run count up by one.
  a_label_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_label_o == $past(result_label_o) + 4'd1)
    else $error("result labels out of order");

  // The divider only finishes during the probability step.
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside its step");

endmodule
`default_nettype wire
